// File: sv/ghbt_pkg.sv
// Shared types and constants for the grid headroom boost tracker.
// No dependencies; imported by every module of the block.
package ghbt_pkg;

  localparam int VOLT_W   = 10;
  localparam int THR_W    = 20;
  localparam int STEP_W   = 17;
  localparam int HYST_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int FRESH_W  = 8;
  localparam int POWER_W  = 21;
  localparam int WATT_W   = 20;
  localparam int MA_W     = 20;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Shared multiplier operand widths: signed A, unsigned B.
  localparam int MUL_A_W = 23;
  localparam int MUL_B_W = 12;
  localparam int MUL_P_W = 36;
  localparam int LIMIT_W = 32;

  localparam logic [PHASE_W-1:0] DEFAULT_PHASES = 2'd3;
  localparam logic [MUL_B_W-1:0] MW_PER_W = 12'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BOOST_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BOOST       = 3'd5;

  typedef struct packed {
    logic [VOLT_W-1:0]   nominal_voltage_v;
    logic [THR_W-1:0]    trigger_margin_w;
    logic [STEP_W-1:0]   boost_step_ma;
    logic [HYST_W-1:0]   hysteresis_cycles;
    logic                max_boost_enable;
    logic [OFFSET_W-1:0] max_boost_ma;
  } cfg_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

endpackage

// File: sv/ghbt_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on ghbt_pkg for operand widths and the request struct.
module ghbt_mul import ghbt_pkg::*; (
  input  logic                      clk_i,
  input  mul_req_t                  req_i,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [MUL_P_W-1:0] prod_d;
  logic signed [MUL_P_W-1:0] a_ext;
  logic signed [MUL_P_W-1:0] b_ext;

  assign a_ext  = MUL_P_W'(req_i.a);
  assign b_ext  = $signed({{(MUL_P_W-MUL_B_W){1'b0}}, req_i.b});
  assign prod_d = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: sv/ghbt_seq.sv
// Sequencer, item capture, boost/counter state and result register.
// Depends on ghbt_pkg and drives the shared multiplier ghbt_mul.
module ghbt_seq import ghbt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FRESH_W-1:0]  fresh_meter_count_i,
  input  logic [POWER_W-1:0]  measured_power_w_i,
  input  logic [WATT_W-1:0]   allocated_power_w_i,
  input  logic                power_limit_valid_i,
  input  logic [WATT_W-1:0]   power_limit_w_i,
  input  logic                current_limit_valid_i,
  input  logic [MA_W-1:0]     current_limit_ma_i,
  input  logic                phase_count_valid_i,
  input  logic [PHASE_W-1:0]  phase_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OFFSET_W-1:0] boost_offset_ma_o,
  output logic                power_reducible_o,
  output logic [HYST_W-1:0]   headroom_run_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LIM  = 2'd1;
  localparam logic [1:0] ST_THR  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_q, state_d;

  // captured request
  logic                      fresh_q, plim_v_q, have_lim_q, red_q;
  logic [WATT_W-1:0]         plim_q;
  logic [MA_W-1:0]           ilim_q;
  logic signed [MUL_A_W-1:0] pthr_q;
  logic [LIMIT_W-1:0]        limit_q;

  // architectural state and result register
  logic                out_valid_q, out_valid_d;
  logic                red_out_q, red_out_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [HYST_W-1:0]   cnt_q, cnt_d;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;

  logic                      accept;
  logic                      commit;
  logic [PHASE_W-1:0]        phases;
  logic signed [MUL_A_W-1:0] power_ext;
  logic signed [MUL_A_W-1:0] thr_ext;
  logic signed [MUL_A_W-1:0] margin;
  logic                      red_new;
  logic                      headroom;
  logic [HYST_W:0]           cnt_inc;
  logic [HYST_W-1:0]         cnt_sat;
  logic [OFFSET_W:0]         off_sum;
  logic [OFFSET_W-1:0]       off_up, off_dn, off_step, step_ext;

  ghbt_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  assign phases    = phase_count_valid_i ? phase_count_i : DEFAULT_PHASES;
  assign power_ext = MUL_A_W'($signed(measured_power_w_i));
  assign thr_ext   = $signed({{(MUL_A_W-THR_W){1'b0}}, cfg_i.trigger_margin_w});
  assign margin    = $signed({{(MUL_A_W-WATT_W){1'b0}}, allocated_power_w_i}) - power_ext;
  assign red_new   = (fresh_meter_count_i != '0) && (allocated_power_w_i != '0) &&
                     (margin > thr_ext);

  // Drive the shared multiplier: phases*voltage, then the limit, then (P+thr)*1000.
  always_comb begin
    mul_req = '0;
    case (state_q)
      ST_IDLE: begin
        mul_req.en = accept;
        mul_req.a  = $signed({{(MUL_A_W-VOLT_W){1'b0}}, cfg_i.nominal_voltage_v});
        mul_req.b  = {{(MUL_B_W-PHASE_W){1'b0}}, phases};
      end
      ST_LIM: begin
        mul_req.en = 1'b1;
        if (plim_v_q) begin
          mul_req.a = $signed({{(MUL_A_W-WATT_W){1'b0}}, plim_q});
          mul_req.b = MW_PER_W;
        end else begin
          mul_req.a = $signed({{(MUL_A_W-MA_W){1'b0}}, ilim_q});
          mul_req.b = prod[MUL_B_W-1:0];
        end
      end
      ST_THR: begin
        mul_req.en = 1'b1;
        mul_req.a  = pthr_q;
        mul_req.b  = MW_PER_W;
      end
      default: mul_req = '0;
    endcase
  end

  // limit - 1000*P > 1000*thr  <=>  limit > 1000*(P + thr)
  assign headroom = $signed({{(MUL_P_W-LIMIT_W){1'b0}}, limit_q}) > prod;

  assign cnt_inc  = {1'b0, cnt_q} + {{HYST_W{1'b0}}, 1'b1};
  assign cnt_sat  = cnt_inc[HYST_W] ? {HYST_W{1'b1}} : cnt_inc[HYST_W-1:0];
  assign step_ext = {{(OFFSET_W-STEP_W){1'b0}}, cfg_i.boost_step_ma};
  assign off_sum  = {1'b0, offset_q} + {1'b0, step_ext};
  assign off_up   = off_sum[OFFSET_W] ? {OFFSET_W{1'b1}} : off_sum[OFFSET_W-1:0];
  assign off_dn   = (offset_q > step_ext) ? (offset_q - step_ext) : '0;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    red_out_d   = red_out_q;
    offset_d    = offset_q;
    cnt_d       = cnt_q;
    off_step    = offset_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LIM;
      ST_LIM:  state_d = ST_THR;
      ST_THR:  state_d = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          red_out_d   = red_q;
          if (!fresh_q || !have_lim_q || (cfg_i.boost_step_ma == '0)) begin
            cnt_d = '0;
          end else begin
            if (headroom) begin
              if (cnt_sat >= cfg_i.hysteresis_cycles) begin
                off_step = off_up;
                cnt_d    = '0;
              end else begin
                cnt_d    = cnt_sat;
              end
            end else begin
              cnt_d    = '0;
              off_step = off_dn;
            end
            if (cfg_i.max_boost_enable && (off_step > cfg_i.max_boost_ma)) begin
              offset_d = cfg_i.max_boost_ma;
            end else begin
              offset_d = off_step;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      red_out_q   <= 1'b0;
      offset_q    <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      red_out_q   <= red_out_d;
      offset_q    <= offset_d;
      cnt_q       <= cnt_d;
    end
  end

  // Capture the request; hold the computed limit once the multiplier has it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fresh_q    <= (fresh_meter_count_i != '0);
      plim_v_q   <= power_limit_valid_i;
      have_lim_q <= power_limit_valid_i || current_limit_valid_i;
      red_q      <= red_new;
      plim_q     <= power_limit_w_i;
      ilim_q     <= current_limit_ma_i;
      pthr_q     <= power_ext + thr_ext;
    end
    if (state_q == ST_THR) begin
      limit_q <= prod[LIMIT_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign power_reducible_o = red_out_q;
  assign boost_offset_ma_o = offset_q;
  assign headroom_run_o    = cnt_q;

endmodule

// File: sv/grid_headroom_boost_tracker_top.sv
// Top level of the grid headroom boost tracker: config registers and the core.
// Depends on ghbt_pkg, ghbt_seq and ghbt_mul.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one metering request per
//    handshake; output channel (out_valid_o/out_ready_i) returns one result
//    per request: boost offset, reducible flag and headroom run count.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes the register at
//    cfg_index_i; it is always ready. Unknown indexes are dropped. Write
//    only while no request is in flight.
//  - Each request passes through the sequencer: the single shared multiplier
//    forms the phase-voltage product, then the grid limit in mW, then
//    1000*(P+thr), and the update state compares and updates the offset and counter.
//  - A new request is accepted only once the previous one has committed;
//    in_ready_o is high only while the sequencer is idle, even while a
//    result waits in the output register.
//  - If the receiver stalls, the result holds in the output register; a
//    following request is accepted and computed but its update holds in
//    the update state until the pending result is taken.
//  - Reset clears the offset and counter and loads the register defaults
//    (230 V, 1000 W threshold, zero step, hysteresis 1, cap disabled).
module grid_headroom_boost_tracker_top import ghbt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FRESH_W-1:0]    fresh_meter_count_i,
  input  logic [POWER_W-1:0]    measured_power_w_i,
  input  logic [WATT_W-1:0]     allocated_power_w_i,
  input  logic                  power_limit_valid_i,
  input  logic [WATT_W-1:0]     power_limit_w_i,
  input  logic                  current_limit_valid_i,
  input  logic [MA_W-1:0]       current_limit_ma_i,
  input  logic                  phase_count_valid_i,
  input  logic [PHASE_W-1:0]    phase_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OFFSET_W-1:0]   boost_offset_ma_o,
  output logic                  power_reducible_o,
  output logic [HYST_W-1:0]     headroom_run_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_NOMINAL_VOLTAGE: cfg_d.nominal_voltage_v = cfg_data_i[VOLT_W-1:0];
        REG_BOOST_THRESHOLD: cfg_d.trigger_margin_w  = cfg_data_i[THR_W-1:0];
        REG_BOOST_STEP:      cfg_d.boost_step_ma     = cfg_data_i[STEP_W-1:0];
        REG_HYSTERESIS:      cfg_d.hysteresis_cycles = cfg_data_i[HYST_W-1:0];
        REG_MAX_BOOST_EN:    cfg_d.max_boost_enable  = cfg_data_i[0];
        REG_MAX_BOOST:       cfg_d.max_boost_ma      = cfg_data_i[OFFSET_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal_voltage_v <= VOLT_W'(230);
      cfg_q.trigger_margin_w  <= THR_W'(1000);
      cfg_q.boost_step_ma     <= '0;
      cfg_q.hysteresis_cycles <= HYST_W'(1);
      cfg_q.max_boost_enable  <= 1'b0;
      cfg_q.max_boost_ma      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ghbt_seq u_seq (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .fresh_meter_count_i   (fresh_meter_count_i),
    .measured_power_w_i    (measured_power_w_i),
    .allocated_power_w_i   (allocated_power_w_i),
    .power_limit_valid_i   (power_limit_valid_i),
    .power_limit_w_i       (power_limit_w_i),
    .current_limit_valid_i (current_limit_valid_i),
    .current_limit_ma_i    (current_limit_ma_i),
    .phase_count_valid_i   (phase_count_valid_i),
    .phase_count_i         (phase_count_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .boost_offset_ma_o     (boost_offset_ma_o),
    .power_reducible_o     (power_reducible_o),
    .headroom_run_o        (headroom_run_o)
  );

  // An accepted request keeps in_ready_o low through the limit, threshold and update states.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("sequencer ready too early after a request");

  // Reaching the hysteresis count always clears the counter, so it never saturates.
  a_counter_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    headroom_run_o != {HYST_W{1'b1}})
    else $error("headroom counter reached saturation");

  // The offset moves only together with a freshly loaded result.
  a_offset_moves_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(boost_offset_ma_o) |-> out_valid_o)
    else $error("boost offset changed without a result");

endmodule
